/* rtl/mmad_pkg.sv */
// ----------------------------------------------------------------------------
// mmad_pkg
// Shared constants, codes and interface types of the min/max/average
// downsampler.
// ----------------------------------------------------------------------------
package mmad_pkg;

    // Default parameter values.
    localparam int LEVEL_NUM_DEF  = 4;
    localparam int RING_DEPTH_DEF = 256;
    localparam int SERIES_NUM_DEF = 4;

    // Field widths.
    localparam int TIME_W  = 40;
    localparam int COUNT_W = 24;
    localparam int VAL_W   = 16;
    localparam int STAT_W  = 3 * VAL_W;
    localparam int FILL_W  = 9;
    localparam int FAC_W   = 8;

    // Largest gap in seconds that keeps the pending aggregates.
    localparam logic [TIME_W-1:0] GAP_LIMIT = TIME_W'(2);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Register reset values.
    localparam logic [TIME_W-1:0] EPOCH_RST = TIME_W'(1700000000);
    localparam logic [FAC_W-1:0]  FAC1_RST  = FAC_W'(60);
    localparam logic [FAC_W-1:0]  FAC2_RST  = FAC_W'(60);
    localparam logic [FAC_W-1:0]  FAC3_RST  = FAC_W'(24);

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_EPOCH = 2'd0;
    localparam logic [1:0] REG_FAC1  = 2'd1;
    localparam logic [1:0] REG_FAC2  = 2'd2;
    localparam logic [1:0] REG_FAC3  = 2'd3;

    // Command codes.
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_ADD_OK  = 2'd0;
    localparam logic [1:0] ST_ADD_REJ = 2'd1;
    localparam logic [1:0] ST_RD_OK   = 2'd2;
    localparam logic [1:0] ST_RD_OOR  = 2'd3;

    // Divider sizes: dividend is a rounded weighted sum magnitude, the
    // divisor a summed count, the quotient a Q17.0 integer magnitude.
    localparam int DIVD_W = 42;
    localparam int DEN_W  = COUNT_W + 1;
    localparam int QUO_W  = 17;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DEN_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } t_div_rsp;

endpackage

/* rtl/mmad_ring_mem.sv */
// ----------------------------------------------------------------------------
// mmad_ring_mem
// Point store of all levels: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mmad_ring_mem #(
    parameter int DEPTH = 1024,
    parameter int DW    = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DW-1:0]            i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DW-1:0]            o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/mmad_div.sv */
// ----------------------------------------------------------------------------
// mmad_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mmad_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mmad_pkg::t_div_req  i_req,
    output mmad_pkg::t_div_rsp  o_rsp
);
    import mmad_pkg::*;

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [DEN_W-1:0]   r_rem;
    logic [DEN_W-1:0]   r_den;
    logic [QUO_W-1:0]   r_low;
    logic [QUO_W-1:0]   r_quo;
    logic [DEN_W:0]     trial;
    logic               fits;

    // Trial subtraction of the next step.
    assign trial = {r_rem, r_low[QUO_W-1]};
    assign fits  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QUO_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder, dividend bits and quotient shift.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.dividend[DIVD_W-1:QUO_W];
            r_low <= i_req.dividend[QUO_W-1:0];
            r_den <= i_req.divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? DEN_W'(trial - {1'b0, r_den}) : DEN_W'(trial);
            r_low <= {r_low[QUO_W-2:0], 1'b0};
            r_quo <= {r_quo[QUO_W-2:0], fits};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

/* rtl/multilevel_min_max_avg_downsampler.sv */
// ----------------------------------------------------------------------------
// multilevel_min_max_avg_downsampler
// Pyramid of ring buffers of timestamped min/max/average points for several
// series, with cascaded consolidation and chronological read-back.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake            | payload
//  request   | in        | i_valid / o_stall    | cmd, timestamp, samples, level,
//            |           |                      | position, series
//  result    | out       | o_valid / i_stall    | status, point fields, level_fill
//  config    | in        | APB psel/penable     | minimum_epoch, three factors
//
//  An in-range read goes through decode, a memory wait and the result stage; any
//  other request but an unrejected add through decode and the result stage. An
//  add stores its point at level zero and each level a full aggregate climbs to;
//  per non-empty pending aggregate, the serial divider runs 17 steps per series.
//  Reset is synchronous; the point store needs no clearing pass.
//  A new request is taken while the previous result is still stalled.
// ----------------------------------------------------------------------------
module multilevel_min_max_avg_downsampler
    import mmad_pkg::*;
#(
    parameter int LEVEL_NUM  = mmad_pkg::LEVEL_NUM_DEF,
    parameter int RING_DEPTH = mmad_pkg::RING_DEPTH_DEF,
    parameter int SERIES_NUM = mmad_pkg::SERIES_NUM_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_cmd,
    input  logic [mmad_pkg::TIME_W-1:0]  i_timestamp,
    input  logic signed [15:0]           i_sample_0,
    input  logic signed [15:0]           i_sample_1,
    input  logic signed [15:0]           i_sample_2,
    input  logic signed [15:0]           i_sample_3,
    input  logic [1:0]                   i_level,
    input  logic [7:0]                   i_position,
    input  logic [1:0]                   i_series,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [1:0]                   o_status,
    output logic [mmad_pkg::TIME_W-1:0]  o_point_time,
    output logic [mmad_pkg::COUNT_W-1:0] o_point_count,
    output logic signed [15:0]           o_point_average,
    output logic signed [15:0]           o_point_minimum,
    output logic signed [15:0]           o_point_maximum,
    output logic [mmad_pkg::FILL_W-1:0]  o_level_fill,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [4:0]                   paddr,
    input  logic [63:0]                  pwdata,
    output logic [63:0]                  prdata,
    output logic                         pready
);

    localparam int LW    = $clog2(LEVEL_NUM);
    localparam int SW    = (SERIES_NUM > 1) ? $clog2(SERIES_NUM) : 1;
    localparam int PW    = $clog2(RING_DEPTH);
    localparam int FW    = $clog2(RING_DEPTH + 1);
    localparam int IW    = PW + 2;
    localparam int DEPTH = LEVEL_NUM * RING_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int DW    = TIME_W + COUNT_W + STAT_W * SERIES_NUM;
    localparam int PL    = LEVEL_NUM - 1;
    localparam int PROD_W = VAL_W + DEN_W;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_RD_WAIT, S_STORE, S_MUL1, S_MUL2, S_SUM,
        S_START, S_DIV, S_UPDATE, S_DONE
    } t_state;

    t_state r_st;

    // Configuration registers.
    logic [TIME_W-1:0] r_epoch;
    logic [FAC_W-1:0]  r_fac [3];

    // Captured request.
    logic [1:0]              r_cmd;
    logic [TIME_W-1:0]       r_ts;
    logic signed [VAL_W-1:0] r_smp [SERIES_NUM];
    logic [1:0]              r_lvl;
    logic [7:0]              r_pos;
    logic [1:0]              r_ser;

    // Ring pointers and fill counts.
    logic [PW-1:0] r_wp   [LEVEL_NUM];
    logic [FW-1:0] r_fill [LEVEL_NUM];
    logic [TIME_W-1:0] r_last;

    // Pending aggregates.
    logic [TIME_W-1:0]       r_pt [PL];
    logic [COUNT_W-1:0]      r_pc [PL];
    logic [FAC_W-1:0]        r_pr [PL];
    logic signed [VAL_W-1:0] r_pa [PL][SERIES_NUM];
    logic signed [VAL_W-1:0] r_pl [PL][SERIES_NUM];
    logic signed [VAL_W-1:0] r_ph [PL][SERIES_NUM];

    // Point being stored, and the aggregate being built.
    logic [LW-1:0]           r_lv;
    logic [SW-1:0]           r_s;
    logic [TIME_W-1:0]       r_p_time;
    logic [COUNT_W-1:0]      r_p_count;
    logic signed [VAL_W-1:0] r_p_avg [SERIES_NUM];
    logic signed [VAL_W-1:0] r_p_lo  [SERIES_NUM];
    logic signed [VAL_W-1:0] r_p_hi  [SERIES_NUM];
    logic [TIME_W-1:0]       r_g_time;
    logic [COUNT_W-1:0]      r_g_count;
    logic signed [VAL_W-1:0] r_g_avg [SERIES_NUM];
    logic signed [VAL_W-1:0] r_g_lo  [SERIES_NUM];
    logic signed [VAL_W-1:0] r_g_hi  [SERIES_NUM];
    logic [DEN_W-1:0]        r_den;
    logic signed [PROD_W-1:0] r_prod1;
    logic signed [PROD_W-1:0] r_prod2;
    logic signed [DIVD_W-1:0] r_num;
    logic                    r_neg;

    // Staged result and output registers.
    logic [1:0]              r_rs_status;
    logic [TIME_W-1:0]       r_rs_time;
    logic [COUNT_W-1:0]      r_rs_count;
    logic signed [VAL_W-1:0] r_rs_avg;
    logic signed [VAL_W-1:0] r_rs_lo;
    logic signed [VAL_W-1:0] r_rs_hi;
    logic [FILL_W-1:0]       r_rs_fill;
    logic                    r_ovalid;
    logic [1:0]              r_o_status;
    logic [TIME_W-1:0]       r_o_time;
    logic [COUNT_W-1:0]      r_o_count;
    logic signed [VAL_W-1:0] r_o_avg;
    logic signed [VAL_W-1:0] r_o_lo;
    logic signed [VAL_W-1:0] r_o_hi;
    logic [FILL_W-1:0]       r_o_fill;

    // Memory and divider connections.
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [DW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [DW-1:0] mem_rdata;
    t_div_req      div_req;
    t_div_rsp      div_rsp;

    logic                    accept;
    logic                    cfg_wr;
    logic signed [VAL_W-1:0] in_smp [4];
    logic [LW-1:0]           rd_lv;
    logic [FW-1:0]           rd_fill;
    logic                    rd_lvl_ok;
    logic                    rd_ok;
    logic [IW-1:0]           rd_idx;
    logic [IW-1:0]           rd_idx_m;
    logic                    ts_reject;
    logic                    ts_gap;
    logic [FAC_W:0]          rcvd_next;
    logic [FAC_W-1:0]        lv_fac;
    logic [STAT_W-1:0]       rd_stat;
    logic [DIVD_W-1:0]       num_mag;

    function automatic logic [AW-1:0] slot_addr(input logic [LW-1:0] lv,
                                                input logic [PW-1:0] idx);
        return AW'(AW'(lv) * AW'(RING_DEPTH)) + AW'(idx);
    endfunction

    assign accept = i_valid && (r_st == S_IDLE);
    assign o_stall = (r_st != S_IDLE);
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    assign in_smp[0] = i_sample_0;
    assign in_smp[1] = i_sample_1;
    assign in_smp[2] = i_sample_2;
    assign in_smp[3] = i_sample_3;

    // Configuration port: writes and read mux.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch  <= EPOCH_RST;
            r_fac[0] <= FAC1_RST;
            r_fac[1] <= FAC2_RST;
            r_fac[2] <= FAC3_RST;
        end else if (cfg_wr) begin
            unique case (paddr[4:3])
                REG_EPOCH: r_epoch  <= pwdata[TIME_W-1:0];
                REG_FAC1:  r_fac[0] <= pwdata[FAC_W-1:0];
                REG_FAC2:  r_fac[1] <= pwdata[FAC_W-1:0];
                REG_FAC3:  r_fac[2] <= pwdata[FAC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:3])
            REG_EPOCH: prdata = 64'(r_epoch);
            REG_FAC1:  prdata = 64'(r_fac[0]);
            REG_FAC2:  prdata = 64'(r_fac[1]);
            REG_FAC3:  prdata = 64'(r_fac[2]);
            default:   prdata = '0;
        endcase
    end

    // Read decode: validity and chronological slot.
    always_comb begin
        rd_lv     = LW'(r_lvl);
        rd_lvl_ok = (3'(r_lvl) < 3'(LEVEL_NUM));
        rd_fill   = rd_lvl_ok ? r_fill[rd_lv] : '0;
        rd_ok     = rd_lvl_ok && (3'(r_ser) < 3'(SERIES_NUM))
                    && (16'(r_pos) < 16'(rd_fill));
        rd_idx    = IW'(r_wp[rd_lv]) + IW'(RING_DEPTH) - IW'(rd_fill) + IW'(r_pos);
        if (rd_idx >= IW'(2 * RING_DEPTH)) begin
            rd_idx_m = rd_idx - IW'(2 * RING_DEPTH);
        end else if (rd_idx >= IW'(RING_DEPTH)) begin
            rd_idx_m = rd_idx - IW'(RING_DEPTH);
        end else begin
            rd_idx_m = rd_idx;
        end
    end

    assign mem_raddr = slot_addr(rd_lv, PW'(rd_idx_m));
    assign rd_stat   = mem_rdata[TIME_W + COUNT_W + STAT_W * SW'(r_ser) +: STAT_W];

    // Timestamp checks of an add.
    assign ts_reject = (r_ts < r_epoch) || ((r_last != '0) && (r_ts <= r_last));
    assign ts_gap    = (r_last != '0)
                       && ({1'b0, r_ts} > ({1'b0, r_last} + {1'b0, GAP_LIMIT}));

    // Store port: the current point at the level's write pointer.
    always_comb begin
        mem_we    = (r_st == S_STORE);
        mem_waddr = slot_addr(r_lv, r_wp[r_lv]);
        mem_wdata = '0;
        mem_wdata[TIME_W-1:0] = r_p_time;
        mem_wdata[TIME_W +: COUNT_W] = r_p_count;
        for (int s = 0; s < SERIES_NUM; s++) begin
            mem_wdata[TIME_W + COUNT_W + STAT_W * s +: STAT_W] =
                {r_p_avg[s], r_p_lo[s], r_p_hi[s]};
        end
    end

    // Divider request: rounded magnitude of the weighted sum.
    assign num_mag          = r_neg ? DIVD_W'(-r_num) : DIVD_W'(r_num);
    assign div_req.start    = (r_st == S_START);
    assign div_req.dividend = num_mag + DIVD_W'(r_den >> 1);
    assign div_req.divisor  = r_den;

    assign lv_fac    = r_fac[2'(r_lv)];
    assign rcvd_next = {1'b0, r_pr[r_lv]} + 1'b1;

    // Control sequencer with its datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_ovalid <= 1'b0;
            r_last   <= '0;
            r_lv     <= '0;
            r_s      <= '0;
            for (int l = 0; l < LEVEL_NUM; l++) begin
                r_wp[l]   <= '0;
                r_fill[l] <= '0;
            end
            for (int l = 0; l < PL; l++) begin
                r_pt[l] <= '0;
                r_pc[l] <= '0;
                r_pr[l] <= '0;
                for (int s = 0; s < SERIES_NUM; s++) begin
                    r_pa[l][s] <= '0;
                    r_pl[l][s] <= '0;
                    r_ph[l][s] <= '0;
                end
            end
        end else begin
            // The result register drains here unless it is reloaded below.
            if (r_ovalid && !i_stall && (r_st != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_st)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd <= i_cmd;
                        r_ts  <= i_timestamp;
                        r_lvl <= i_level;
                        r_pos <= i_position;
                        r_ser <= i_series;
                        for (int s = 0; s < SERIES_NUM; s++) begin
                            r_smp[s] <= in_smp[s];
                        end
                        r_st <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_rs_time   <= '0;
                    r_rs_count  <= '0;
                    r_rs_avg    <= '0;
                    r_rs_lo     <= '0;
                    r_rs_hi     <= '0;
                    r_rs_fill   <= (r_cmd == CMD_READ) ? FILL_W'(rd_fill) : '0;
                    case (r_cmd)
                        CMD_ADD: begin
                            if (ts_reject) begin
                                r_rs_status <= ST_ADD_REJ;
                                r_st        <= S_DONE;
                            end else begin
                                if (ts_gap) begin
                                    for (int l = 0; l < PL; l++) begin
                                        r_pt[l] <= '0;
                                        r_pc[l] <= '0;
                                        r_pr[l] <= '0;
                                        for (int s = 0; s < SERIES_NUM; s++) begin
                                            r_pa[l][s] <= '0;
                                            r_pl[l][s] <= '0;
                                            r_ph[l][s] <= '0;
                                        end
                                    end
                                end
                                r_last    <= r_ts;
                                r_p_time  <= r_ts;
                                r_p_count <= COUNT_W'(1);
                                for (int s = 0; s < SERIES_NUM; s++) begin
                                    r_p_avg[s] <= r_smp[s];
                                    r_p_lo[s]  <= r_smp[s];
                                    r_p_hi[s]  <= r_smp[s];
                                end
                                r_lv <= '0;
                                r_st <= S_STORE;
                            end
                        end
                        CMD_READ: begin
                            r_rs_status <= ST_RD_OOR;
                            r_st        <= rd_ok ? S_RD_WAIT : S_DONE;
                        end
                        CMD_CLEAR: begin
                            r_rs_status <= ST_ADD_OK;
                            r_st        <= S_DONE;
                            r_last      <= '0;
                            for (int l = 0; l < LEVEL_NUM; l++) begin
                                r_wp[l]   <= '0;
                                r_fill[l] <= '0;
                            end
                            for (int l = 0; l < PL; l++) begin
                                r_pt[l] <= '0;
                                r_pc[l] <= '0;
                                r_pr[l] <= '0;
                                for (int s = 0; s < SERIES_NUM; s++) begin
                                    r_pa[l][s] <= '0;
                                    r_pl[l][s] <= '0;
                                    r_ph[l][s] <= '0;
                                end
                            end
                        end
                        default: begin
                            r_rs_status <= ST_ADD_REJ;
                            r_st        <= S_DONE;
                        end
                    endcase
                end
                S_RD_WAIT: begin
                    r_rs_status <= ST_RD_OK;
                    r_rs_time   <= mem_rdata[TIME_W-1:0];
                    r_rs_count  <= mem_rdata[TIME_W +: COUNT_W];
                    r_rs_avg    <= rd_stat[STAT_W-1 -: VAL_W];
                    r_rs_lo     <= rd_stat[VAL_W +: VAL_W];
                    r_rs_hi     <= rd_stat[VAL_W-1:0];
                    r_st        <= S_DONE;
                end
                S_STORE: begin
                    r_wp[r_lv] <= (r_wp[r_lv] == PW'(RING_DEPTH - 1)) ?
                                  '0 : r_wp[r_lv] + 1'b1;
                    if (r_fill[r_lv] < FW'(RING_DEPTH)) begin
                        r_fill[r_lv] <= r_fill[r_lv] + 1'b1;
                    end
                    if (r_lv == LW'(LEVEL_NUM - 1)) begin
                        r_rs_status <= ST_ADD_OK;
                        r_st        <= S_DONE;
                    end else if (r_pc[r_lv] == '0) begin
                        // Empty aggregate takes the point as it is.
                        r_g_time  <= r_p_time;
                        r_g_count <= r_p_count;
                        for (int s = 0; s < SERIES_NUM; s++) begin
                            r_g_avg[s] <= r_p_avg[s];
                            r_g_lo[s]  <= r_p_lo[s];
                            r_g_hi[s]  <= r_p_hi[s];
                        end
                        r_st <= S_UPDATE;
                    end else begin
                        r_den     <= DEN_W'(r_pc[r_lv]) + DEN_W'(r_p_count);
                        r_g_count <= ((DEN_W'(r_pc[r_lv]) + DEN_W'(r_p_count))
                                      > DEN_W'(COUNT_MAX)) ? COUNT_MAX :
                                     r_pc[r_lv] + r_p_count;
                        r_g_time  <= (r_p_time > r_pt[r_lv]) ? r_p_time : r_pt[r_lv];
                        for (int s = 0; s < SERIES_NUM; s++) begin
                            r_g_lo[s] <= (r_p_lo[s] < r_pl[r_lv][s]) ?
                                         r_p_lo[s] : r_pl[r_lv][s];
                            r_g_hi[s] <= (r_p_hi[s] > r_ph[r_lv][s]) ?
                                         r_p_hi[s] : r_ph[r_lv][s];
                        end
                        r_s  <= '0;
                        r_st <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_prod1 <= r_pa[r_lv][r_s] * $signed({1'b0, r_pc[r_lv]});
                    r_st    <= S_MUL2;
                end
                S_MUL2: begin
                    r_prod2 <= r_p_avg[r_s] * $signed({1'b0, r_p_count});
                    r_st    <= S_SUM;
                end
                S_SUM: begin
                    r_num <= DIVD_W'(r_prod1) + DIVD_W'(r_prod2);
                    r_neg <= ((DIVD_W'(r_prod1) + DIVD_W'(r_prod2)) < 0);
                    r_st  <= S_START;
                end
                S_START: begin
                    r_st <= S_DIV;
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_g_avg[r_s] <= r_neg ? -VAL_W'(div_rsp.quotient)
                                              : VAL_W'(div_rsp.quotient);
                        if (r_s == SW'(SERIES_NUM - 1)) begin
                            r_st <= S_UPDATE;
                        end else begin
                            r_s  <= r_s + 1'b1;
                            r_st <= S_MUL1;
                        end
                    end
                end
                S_UPDATE: begin
                    if (rcvd_next < {1'b0, lv_fac}) begin
                        // Aggregate still open: write it back.
                        r_pr[r_lv] <= rcvd_next[FAC_W-1:0];
                        r_pt[r_lv] <= r_g_time;
                        r_pc[r_lv] <= r_g_count;
                        for (int s = 0; s < SERIES_NUM; s++) begin
                            r_pa[r_lv][s] <= r_g_avg[s];
                            r_pl[r_lv][s] <= r_g_lo[s];
                            r_ph[r_lv][s] <= r_g_hi[s];
                        end
                        r_rs_status <= ST_ADD_OK;
                        r_st        <= S_DONE;
                    end else begin
                        // Aggregate complete: clear it and push it up.
                        r_pr[r_lv] <= '0;
                        r_pt[r_lv] <= '0;
                        r_pc[r_lv] <= '0;
                        for (int s = 0; s < SERIES_NUM; s++) begin
                            r_pa[r_lv][s] <= '0;
                            r_pl[r_lv][s] <= '0;
                            r_ph[r_lv][s] <= '0;
                            r_p_avg[s]    <= r_g_avg[s];
                            r_p_lo[s]     <= r_g_lo[s];
                            r_p_hi[s]     <= r_g_hi[s];
                        end
                        r_p_time  <= r_g_time;
                        r_p_count <= r_g_count;
                        r_lv      <= r_lv + 1'b1;
                        r_st      <= S_STORE;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid   <= 1'b1;
                        r_o_status <= r_rs_status;
                        r_o_time   <= r_rs_time;
                        r_o_count  <= r_rs_count;
                        r_o_avg    <= r_rs_avg;
                        r_o_lo     <= r_rs_lo;
                        r_o_hi     <= r_rs_hi;
                        r_o_fill   <= r_rs_fill;
                        r_st       <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_valid         = r_ovalid;
    assign o_status        = r_o_status;
    assign o_point_time    = r_o_time;
    assign o_point_count   = r_o_count;
    assign o_point_average = r_o_avg;
    assign o_point_minimum = r_o_lo;
    assign o_point_maximum = r_o_hi;
    assign o_level_fill    = r_o_fill;

    mmad_ring_mem #(
        .DEPTH (DEPTH),
        .DW    (DW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    mmad_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

`ifndef SYNTHESIS
    // Level zero never holds more points than its ring.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill[0] <= FW'(RING_DEPTH))
        else $error("level zero fill beyond ring depth");

    // The divider only finishes while the sequencer waits for it.
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_st == S_DIV))
        else $error("divider result outside of the divide step");

    // A store at level zero always advances its write pointer.
    a_store_wp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_STORE) && (r_lv == '0) |=> (r_wp[0] != $past(r_wp[0])))
        else $error("write pointer did not advance on store");
`endif

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multilevel min/max/average downsampler. Requests
// (adds, reads, clears and the unused command) are driven from a queue. Each
// accepted request is run through a behavioral copy of the point pyramid, and
// every result is checked field by field against the oldest prediction. The
// configuration registers are rewritten between phases while the block is
// idle.
// ----------------------------------------------------------------------------
module tb;
    import mmad_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LVLS  = 4;
    localparam int DEPTH = 256;
    localparam int SER   = 4;

    typedef struct {
        logic [1:0]         cmd;
        logic [TIME_W-1:0]  ts;
        logic signed [15:0] smp [SER];
        logic [1:0]         lvl;
        logic [7:0]         pos;
        logic [1:0]         ser;
    } req_t;

    typedef struct {
        logic [1:0]         status;
        logic [TIME_W-1:0]  ptime;
        logic [COUNT_W-1:0] pcount;
        logic signed [15:0] pavg;
        logic signed [15:0] pmin;
        logic signed [15:0] pmax;
        logic [FILL_W-1:0]  fill;
    } res_t;

    typedef struct {
        logic [TIME_W-1:0] t;
        int unsigned       n;
        int                av [SER];
        int                lo [SER];
        int                hi [SER];
    } point_t;

    logic               i_clk, i_rst_n;
    logic               i_valid, o_stall, o_valid, i_stall;
    logic [1:0]         i_cmd, i_level, i_series;
    logic [TIME_W-1:0]  i_timestamp;
    logic signed [15:0] i_sample_0, i_sample_1, i_sample_2, i_sample_3;
    logic [7:0]         i_position;
    logic [1:0]         o_status;
    logic [TIME_W-1:0]  o_point_time;
    logic [COUNT_W-1:0] o_point_count;
    logic signed [15:0] o_point_average, o_point_minimum, o_point_maximum;
    logic [FILL_W-1:0]  o_level_fill;
    logic               psel, penable, pwrite, pready;
    logic [4:0]         paddr;
    logic [63:0]        pwdata, prdata;

    multilevel_min_max_avg_downsampler i_dut (.*);

    // Pyramid copy used for prediction.
    point_t            ring [LVLS][DEPTH];
    point_t            pend [LVLS-1];
    int unsigned       pend_rx [LVLS-1];
    int unsigned       wr_ptr [LVLS];
    int unsigned       fill_cnt [LVLS];
    logic [TIME_W-1:0] last_ts;
    logic [TIME_W-1:0] epoch_reg;
    logic [7:0]        factor_reg [LVLS-1];

    req_t  request_q [$];
    res_t  expected_q [$];
    int    errors = 0;
    int    idle_pct = 20;
    bit    hold = 0;
    bit    accepted = 0;
    logic [TIME_W-1:0] gen_ts;

    // Clock.
    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    function automatic point_t empty_point();
        point_t p;
        p.t = '0;
        p.n = 0;
        for (int i = 0; i < SER; i++) begin
            p.av[i] = 0; p.lo[i] = 0; p.hi[i] = 0;
        end
        return p;
    endfunction

    function automatic void clear_pending();
        for (int l = 0; l < LVLS - 1; l++) begin
            pend[l] = empty_point();
            pend_rx[l] = 0;
        end
    endfunction

    function automatic void clear_pyramid();
        for (int l = 0; l < LVLS; l++) begin
            wr_ptr[l] = 0;
            fill_cnt[l] = 0;
        end
        clear_pending();
        last_ts = '0;
    endfunction

    // Weighted merge of two points; the average is rounded half away from zero.
    function automatic point_t merge_points(point_t a, point_t b);
        point_t r;
        longint den, num, mag, q;
        if (b.n == 0) return a;
        if (a.n == 0) return b;
        r = a;
        den = longint'(a.n) + longint'(b.n);
        for (int i = 0; i < SER; i++) begin
            num = longint'(a.av[i]) * longint'(a.n) + longint'(b.av[i]) * longint'(b.n);
            mag = (num < 0) ? -num : num;
            q = (mag + den / 2) / den;
            r.av[i] = (num < 0) ? -int'(q) : int'(q);
            if (b.lo[i] < r.lo[i]) r.lo[i] = b.lo[i];
            if (b.hi[i] > r.hi[i]) r.hi[i] = b.hi[i];
        end
        r.n = (den > longint'(COUNT_MAX)) ? int'(COUNT_MAX) : int'(den);
        if (b.t > r.t) r.t = b.t;
        return r;
    endfunction

    // Store a new level 0 point and push completed aggregates upward.
    function automatic void cascade_point(point_t p);
        point_t agg;
        for (int l = 0; l < LVLS; l++) begin
            ring[l][wr_ptr[l]] = p;
            wr_ptr[l] = (wr_ptr[l] + 1) % DEPTH;
            if (fill_cnt[l] < DEPTH) fill_cnt[l]++;
            if (l == LVLS - 1) break;
            agg = merge_points(pend[l], p);
            pend_rx[l] = (pend_rx[l] + 1) & 8'hFF;
            if (pend_rx[l] < factor_reg[l]) begin
                pend[l] = agg;
                break;
            end
            pend[l] = empty_point();
            pend_rx[l] = 0;
            p = agg;
        end
    endfunction

    // Work out the result of one request and update the pyramid copy.
    function automatic res_t predict_result(req_t r);
        res_t   e;
        point_t p;
        int unsigned oldest, slot;
        e = '{default: '0};
        case (r.cmd)
            CMD_ADD: begin
                if (r.ts < epoch_reg || (last_ts != 0 && r.ts <= last_ts)) begin
                    e.status = ST_ADD_REJ;
                end else begin
                    if (last_ts != 0 && r.ts - last_ts > GAP_LIMIT) clear_pending();
                    p.t = r.ts;
                    p.n = 1;
                    for (int i = 0; i < SER; i++) begin
                        p.av[i] = r.smp[i]; p.lo[i] = r.smp[i]; p.hi[i] = r.smp[i];
                    end
                    last_ts = r.ts;
                    cascade_point(p);
                    e.status = ST_ADD_OK;
                end
            end
            CMD_READ: begin
                e.status = ST_RD_OOR;
                e.fill = FILL_W'(fill_cnt[r.lvl]);
                if (r.pos < fill_cnt[r.lvl]) begin
                    oldest = (wr_ptr[r.lvl] + DEPTH - fill_cnt[r.lvl]) % DEPTH;
                    slot = (oldest + r.pos) % DEPTH;
                    p = ring[r.lvl][slot];
                    e.status = ST_RD_OK;
                    e.ptime = p.t;
                    e.pcount = COUNT_W'(p.n);
                    e.pavg = 16'(p.av[r.ser]);
                    e.pmin = 16'(p.lo[r.ser]);
                    e.pmax = 16'(p.hi[r.ser]);
                end
            end
            CMD_CLEAR: begin
                clear_pyramid();
                e.status = ST_ADD_OK;
            end
            default: e.status = ST_ADD_REJ;
        endcase
        return e;
    endfunction

    // Request driver: a new request only after the previous one was taken.
    always @(negedge i_clk) begin
        req_t r;
        if (!i_valid || accepted) begin
            if (!i_rst_n || hold || request_q.size() == 0 ||
                $urandom_range(99) < idle_pct) begin
                i_valid <= 1'b0;
            end else begin
                r = request_q.pop_front();
                i_valid     <= 1'b1;
                i_cmd       <= r.cmd;
                i_timestamp <= r.ts;
                i_sample_0  <= r.smp[0];
                i_sample_1  <= r.smp[1];
                i_sample_2  <= r.smp[2];
                i_sample_3  <= r.smp[3];
                i_level     <= r.lvl;
                i_position  <= r.pos;
                i_series    <= r.ser;
            end
        end
        i_stall <= i_rst_n && ($urandom_range(99) < idle_pct);
    end

    // Prediction at the accepting edge.
    always @(posedge i_clk) begin
        req_t r;
        accepted <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            r.cmd = i_cmd;
            r.ts = i_timestamp;
            r.smp[0] = i_sample_0;
            r.smp[1] = i_sample_1;
            r.smp[2] = i_sample_2;
            r.smp[3] = i_sample_3;
            r.lvl = i_level;
            r.pos = i_position;
            r.ser = i_series;
            expected_q.push_back(predict_result(r));
        end
    end

    task automatic report_mismatch(string field, longint got, longint want);
        $display("%0t: %s mismatch, got %0h expected %0h", $realtime, field, got, want);
        errors++;
    endtask

    // Result monitor.
    always @(posedge i_clk) begin
        res_t e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result status", o_status, 0);
            end else begin
                e = expected_q.pop_front();
                if (o_status !== e.status) report_mismatch("status", o_status, e.status);
                if (o_point_time !== e.ptime) report_mismatch("time", o_point_time, e.ptime);
                if (o_point_count !== e.pcount)
                    report_mismatch("count", o_point_count, e.pcount);
                if (o_point_average !== e.pavg)
                    report_mismatch("average", o_point_average, e.pavg);
                if (o_point_minimum !== e.pmin)
                    report_mismatch("minimum", o_point_minimum, e.pmin);
                if (o_point_maximum !== e.pmax)
                    report_mismatch("maximum", o_point_maximum, e.pmax);
                if (o_level_fill !== e.fill) report_mismatch("fill", o_level_fill, e.fill);
            end
        end
    end

    task automatic write_register(logic [1:0] index, logic [63:0] value);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= 5'(index) << 3;
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (index == REG_EPOCH) epoch_reg = value[TIME_W-1:0];
        else factor_reg[index - 1] = value[7:0];
    endtask

    // Wait until every queued request was taken and every result arrived.
    task automatic drain();
        wait (request_q.size() == 0);
        @(posedge i_clk);
        wait (!i_valid);
        wait (expected_q.size() == 0);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic void push_request(logic [1:0] cmd, logic [TIME_W-1:0] ts,
                                         int s0, int s1, int s2, int s3,
                                         int lvl, int pos, int ser);
        req_t r;
        r.cmd = cmd; r.ts = ts;
        r.smp[0] = 16'(s0); r.smp[1] = 16'(s1); r.smp[2] = 16'(s2); r.smp[3] = 16'(s3);
        r.lvl = 2'(lvl); r.pos = 8'(pos); r.ser = 2'(ser);
        request_q.push_back(r);
    endfunction

    function automatic int rand_sample();
        if ($urandom_range(3) == 0) return int'($urandom_range(20)) - 10;
        return int'($urandom_range(65535));
    endfunction

    // Random mix: mostly consecutive adds, with reads, gaps, rejects and clears.
    function automatic void random_requests(int num);
        int k;
        logic [TIME_W-1:0] ts;
        for (int i = 0; i < num; i++) begin
            k = $urandom_range(99);
            if (k < 58) begin
                gen_ts += ($urandom_range(9) == 0) ? 2 : 1;
                if ($urandom_range(30) == 0) gen_ts += $urandom_range(40, 3);
                push_request(CMD_ADD, gen_ts, rand_sample(), rand_sample(),
                             rand_sample(), rand_sample(), 0, 0, 0);
            end else if (k < 63) begin
                ts = gen_ts - $urandom_range(3);
                if ($urandom_range(3) == 0) ts = {$urandom, $urandom} & 40'hFF_FFFF_FFFF;
                push_request(CMD_ADD, ts, rand_sample(), rand_sample(),
                             rand_sample(), rand_sample(), 0, 0, 0);
            end else if (k < 96) begin
                push_request(CMD_READ, {$urandom, $urandom}, $urandom, $urandom,
                             $urandom, $urandom, $urandom_range(3),
                             ($urandom_range(1) != 0) ? $urandom_range(255)
                                                      : $urandom_range(12),
                             $urandom_range(3));
            end else if (k < 98) begin
                push_request(CMD_CLEAR, {$urandom, $urandom}, $urandom, 0, 0, 0,
                             $urandom_range(3), $urandom, $urandom_range(3));
            end else begin
                push_request(2'd3, gen_ts + 1, 0, 0, 0, 0, 0, 0, 0);
            end
        end
    endfunction

    initial begin
        logic [TIME_W-1:0] e0;
        i_rst_n = 1'b0; i_valid = 1'b0; i_stall = 1'b0;
        i_cmd = CMD_ADD; i_timestamp = '0;
        i_sample_0 = '0; i_sample_1 = '0; i_sample_2 = '0; i_sample_3 = '0;
        i_level = '0; i_position = '0; i_series = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        epoch_reg = EPOCH_RST;
        factor_reg[0] = FAC1_RST; factor_reg[1] = FAC2_RST; factor_reg[2] = FAC3_RST;
        clear_pyramid();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Small factors so aggregates reach the top level quickly.
        e0 = 40'h80_0000_0000 + {$urandom_range(32'h7FFF_FFFF), 7'h0};
        write_register(REG_EPOCH, 64'(e0));
        write_register(REG_FAC1, 64'd3);
        write_register(REG_FAC2, 64'd2);
        write_register(REG_FAC3, 64'd2);

        // Directed: extremes, rounding ties, rejects, gap, reads and clear.
        push_request(CMD_ADD, e0 - 1, 0, 0, 0, 0, 0, 0, 0);
        push_request(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0);
        push_request(CMD_ADD, e0, 16'h8000, 16'h7FFF, 1, -1, 0, 0, 0);
        push_request(CMD_ADD, e0 + 1, 16'h7FFF, 16'h8000, 2, -2, 0, 0, 0);
        push_request(CMD_ADD, e0 + 1, 5, 5, 5, 5, 0, 0, 0);
        push_request(CMD_ADD, e0 + 3, 16'hFFFF, 0, 16'h7FFF, 16'h8000, 0, 0, 0);
        for (int s = 0; s < SER; s++) begin
            push_request(CMD_READ, 0, 0, 0, 0, 0, 0, 0, s);
            push_request(CMD_READ, 0, 0, 0, 0, 0, 1, 0, s);
        end
        push_request(CMD_ADD, e0 + 10, 3, 3, 3, 3, 0, 0, 0);
        push_request(CMD_READ, 0, 0, 0, 0, 0, 0, 3, 1);
        push_request(CMD_READ, 0, 0, 0, 0, 0, 0, 255, 2);
        push_request(CMD_READ, 0, 0, 0, 0, 0, 3, 0, 3);
        push_request(CMD_READ, 0, 0, 0, 0, 0, 2, 0, 0);
        push_request(2'd3, e0 + 11, 0, 0, 0, 0, 0, 0, 0);
        push_request(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
        push_request(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0);
        push_request(CMD_ADD, e0 + 5, 7, 7, 7, 7, 0, 0, 0);
        gen_ts = e0 + 5;
        drain();

        // Long stretch without idling on either side.
        idle_pct = 0;
        random_requests(150);
        drain();
        idle_pct = 20;
        random_requests(250);

        // Hold the sender until the block has caught up.
        wait (request_q.size() == 0);
        hold = 1;
        wait (expected_q.size() == 0);
        hold = 0;
        random_requests(60);
        drain();

        // Lowest epoch and factors of one: every point moves straight up.
        write_register(REG_EPOCH, 64'd0);
        write_register(REG_FAC1, 64'd1);
        write_register(REG_FAC2, 64'd1);
        write_register(REG_FAC3, 64'd1);
        push_request(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
        push_request(CMD_ADD, 0, 1, 2, 3, 4, 0, 0, 0);
        push_request(CMD_ADD, 0, 4, 3, 2, 1, 0, 0, 0);
        gen_ts = 0;
        random_requests(140);
        drain();

        // Highest epoch and factors.
        write_register(REG_EPOCH, 64'hFF_FFFF_FFFF);
        write_register(REG_FAC1, 64'd255);
        write_register(REG_FAC2, 64'd255);
        write_register(REG_FAC3, 64'd255);
        push_request(CMD_ADD, 40'hFF_FFFF_FFFE, 1, 1, 1, 1, 0, 0, 0);
        push_request(CMD_ADD, 40'hFF_FFFF_FFFF, 9, 9, 9, 9, 0, 0, 0);
        push_request(CMD_ADD, 40'hFF_FFFF_FFFF, 9, 9, 9, 9, 0, 0, 0);
        push_request(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0);
        drain();

        // Mid-range settings for the rest of the run.
        e0 = {$urandom_range(255), $urandom} & 40'h7F_FFFF_FFFF;
        write_register(REG_EPOCH, 64'(e0));
        write_register(REG_FAC1, 64'($urandom_range(6, 2)));
        write_register(REG_FAC2, 64'($urandom_range(4, 2)));
        write_register(REG_FAC3, 64'($urandom_range(3, 2)));
        push_request(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
        gen_ts = e0;
        random_requests(300);
        drain();

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
